@@ rtl/core/lrm_pkg.sv @@
// Package for the lottery draw block: seed, masks and the Tausworthe step function.
package lrm_pkg;

	localparam int unsigned CompWidth  = 32;
	localparam int unsigned DrawWidth  = 31;
	localparam int unsigned CountWidth = 32;
	localparam int unsigned DivSteps   = 32;

	localparam logic [CompWidth-1:0] SeedValue = 32'd12345;
	localparam logic [CompWidth-1:0] MaskOne   = 32'd4294967294;
	localparam logic [CompWidth-1:0] MaskTwo   = 32'd4294967288;
	localparam logic [CompWidth-1:0] MaskThree = 32'd4294967280;
	localparam logic [CompWidth-1:0] MaskFour  = 32'd4294967168;

	// One step of a Tausworthe component, logical shifts throughout.
	function automatic logic [CompWidth-1:0] taus_step(
		input logic [CompWidth-1:0] z,
		input int unsigned          s1,
		input int unsigned          s2,
		input int unsigned          s3,
		input logic [CompWidth-1:0] mask
	);
		logic [CompWidth-1:0] b;
		b = ((z << s1) ^ z) >> s2;
		return ((z & mask) << s3) ^ b;
	endfunction

endpackage

@@ rtl/core/lottery_random_mod.sv @@
// Lottery draw: combined Tausworthe generator reduced modulo a ticket count.
// Each transaction on the slave side carries a signed 32-bit ticket count. A positive count
// advances the four Tausworthe components once, XORs them and returns the unsigned
// remainder of that word by the count; a zero or negative count returns 1 and leaves the
// generator untouched. A positive count steps the generator when it is accepted, then runs
// the radix-2 restoring divider (one quotient bit per cycle) and loads the output register;
// a non-positive count only loads the output register. The output register holds a
// result until the master side takes it while the block already accepts and works on the
// next count; a finished result waits in the divider until the output register is free.
module lottery_random_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] ticket_count (signed)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [30:0] draw, [31] zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	localparam int unsigned CntWidth = $clog2(lrm_pkg::DivSteps);

	state_t                               state_q;
	logic [lrm_pkg::CompWidth-1:0]        comp_one_q;
	logic [lrm_pkg::CompWidth-1:0]        comp_two_q;
	logic [lrm_pkg::CompWidth-1:0]        comp_three_q;
	logic [lrm_pkg::CompWidth-1:0]        comp_four_q;
	logic [lrm_pkg::CompWidth-1:0]        quo_q;
	logic [lrm_pkg::DrawWidth-1:0]        rem_q;
	logic [lrm_pkg::DrawWidth-1:0]        div_q;
	logic [CntWidth-1:0]                  cnt_q;
	logic                                 m_tvalid_q;
	logic [lrm_pkg::DrawWidth-1:0]        draw_q;

	logic                                 accept;
	logic                                 count_pos;
	logic [lrm_pkg::CompWidth-1:0]        nxt_one;
	logic [lrm_pkg::CompWidth-1:0]        nxt_two;
	logic [lrm_pkg::CompWidth-1:0]        nxt_three;
	logic [lrm_pkg::CompWidth-1:0]        nxt_four;
	logic [lrm_pkg::DrawWidth:0]          trial;
	logic [lrm_pkg::DrawWidth:0]          diff;
	logic [lrm_pkg::DrawWidth-1:0]        rem_nxt;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign count_pos = ~s_tdata[lrm_pkg::CountWidth-1] && (s_tdata != '0);

	assign nxt_one   = lrm_pkg::taus_step(comp_one_q, 6, 13, 18, lrm_pkg::MaskOne);
	assign nxt_two   = lrm_pkg::taus_step(comp_two_q, 2, 27, 2, lrm_pkg::MaskTwo);
	assign nxt_three = lrm_pkg::taus_step(comp_three_q, 13, 21, 7, lrm_pkg::MaskThree);
	assign nxt_four  = lrm_pkg::taus_step(comp_four_q, 3, 12, 13, lrm_pkg::MaskFour);

	// Restoring step: shift the next dividend bit in, subtract when the divisor fits.
	assign trial   = {rem_q, quo_q[lrm_pkg::CompWidth-1]};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[lrm_pkg::DrawWidth-1:0]
	                                          : trial[lrm_pkg::DrawWidth-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			comp_one_q   <= lrm_pkg::SeedValue;
			comp_two_q   <= lrm_pkg::SeedValue;
			comp_three_q <= lrm_pkg::SeedValue;
			comp_four_q  <= lrm_pkg::SeedValue;
			quo_q        <= '0;
			rem_q        <= '0;
			div_q        <= '0;
			cnt_q        <= '0;
			m_tvalid_q   <= 1'b0;
			draw_q       <= '0;
		end else begin
			// Drop valid on a take, unless the hold state reloads the register this cycle.
			if (m_tvalid_q && m_tready && (state_q != ST_HOLD)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (count_pos) begin
							comp_one_q   <= nxt_one;
							comp_two_q   <= nxt_two;
							comp_three_q <= nxt_three;
							comp_four_q  <= nxt_four;
							quo_q        <= nxt_one ^ nxt_two ^ nxt_three ^ nxt_four;
							rem_q        <= '0;
							div_q        <= s_tdata[lrm_pkg::DrawWidth-1:0];
							cnt_q        <= '0;
							state_q      <= ST_DIVIDE;
						end else begin
							rem_q   <= lrm_pkg::DrawWidth'(1);
							state_q <= ST_HOLD;
						end
					end
				end
				ST_DIVIDE: begin
					rem_q <= rem_nxt;
					quo_q <= quo_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntWidth'(lrm_pkg::DivSteps - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					// Hand over only when the output register is free or being taken.
					if (!m_tvalid_q || m_tready) begin
						draw_q     <= rem_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, draw_q};

endmodule

@@ tb/sv/lottery_random_mod_tb.sv @@
// Testbench for lottery_random_mod: directed table plus random ticket counts, scoreboarded.
module lottery_random_mod_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] ticket_count (signed)
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // [30:0] draw, [31] zero

	typedef struct packed {
		logic [31:0]                   count;
		logic                          typed;  // draw below is fixed, not predicted
		logic [lrm_pkg::DrawWidth-1:0] draw;
	} ticket_row_t;

	localparam int NumRows = 18;
	localparam int NumRandom = 450;

	ticket_row_t ticket_rows [NumRows] = '{
		'{32'h0000_0000, 1'b1, 31'd1},
		'{32'hFFFF_FFFF, 1'b1, 31'd1},
		'{32'h8000_0000, 1'b1, 31'd1},
		'{32'h8000_0001, 1'b1, 31'd1},
		'{32'h0000_0001, 1'b1, 31'd0},
		'{32'h0000_0001, 1'b1, 31'd0},
		'{32'h0000_0002, 1'b0, 31'd0},
		'{32'h0000_0003, 1'b0, 31'd0},
		'{32'h7FFF_FFFF, 1'b0, 31'd0},
		'{32'h7FFF_FFFE, 1'b0, 31'd0},
		'{32'h4000_0000, 1'b0, 31'd0},
		'{32'h0000_0010, 1'b0, 31'd0},
		'{32'h0000_FFFF, 1'b0, 31'd0},
		'{32'hFFFF_0000, 1'b1, 31'd1},
		'{32'h0000_0005, 1'b0, 31'd0},
		'{32'h0000_0000, 1'b1, 31'd1},
		'{32'hAAAA_AAAA, 1'b1, 31'd1},
		'{32'h5555_5555, 1'b0, 31'd0}
	};

	logic [lrm_pkg::CompWidth-1:0] gen_a, gen_b, gen_c, gen_d;
	logic [lrm_pkg::DrawWidth-1:0] draws_due [$];
	int                            errors;
	bit                            calm;  // no idling on either side while set

	lottery_random_mod DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("lottery_random_mod test failed");
		$finish;
	end

	// Advance the generator for a positive count and reduce the mixed word.
	function automatic logic [lrm_pkg::DrawWidth-1:0] next_draw(input logic [31:0] count);
		logic [lrm_pkg::CompWidth-1:0] fb;
		logic [lrm_pkg::CompWidth-1:0] word;
		if (count[31] || count == '0)
			return lrm_pkg::DrawWidth'(1);
		fb    = (gen_a ^ (gen_a << 6)) >> 13;
		gen_a = fb ^ ((gen_a & lrm_pkg::MaskOne) << 18);
		fb    = (gen_b ^ (gen_b << 2)) >> 27;
		gen_b = fb ^ ((gen_b & lrm_pkg::MaskTwo) << 2);
		fb    = (gen_c ^ (gen_c << 13)) >> 21;
		gen_c = fb ^ ((gen_c & lrm_pkg::MaskThree) << 7);
		fb    = (gen_d ^ (gen_d << 3)) >> 12;
		gen_d = fb ^ ((gen_d & lrm_pkg::MaskFour) << 13);
		word  = gen_a ^ gen_b ^ gen_c ^ gen_d;
		return lrm_pkg::DrawWidth'(word % count);
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic logic [31:0] random_count();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {1'b1, v[30:0]};
			2, 3, 4, 5: return $urandom_range(1, 16);
			6, 7: return $urandom_range(1, 65535);
			default: return (v[30:0] == '0) ? 32'd1 : {1'b0, v[30:0]};
		endcase
	endfunction

	// Hold the count until the slave side takes it, then queue its draw.
	task automatic offer_count(input logic [31:0] count, input logic typed,
	                           input logic [lrm_pkg::DrawWidth-1:0] typed_draw);
		int                            gap;
		logic [lrm_pkg::DrawWidth-1:0] want;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= count;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = next_draw(count);
		draws_due.push_back(typed ? typed_draw : want);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		errors   = 0;
		calm     = 1'b0;
		gen_a    = lrm_pkg::SeedValue;
		gen_b    = lrm_pkg::SeedValue;
		gen_c    = lrm_pkg::SeedValue;
		gen_d    = lrm_pkg::SeedValue;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (ticket_rows[i])
			offer_count(ticket_rows[i].count, ticket_rows[i].typed, ticket_rows[i].draw);

		// drain everything before the random part
		s_tvalid <= 1'b0;
		wait (draws_due.size() == 0);
		@(posedge clk);

		for (int n = 0; n < NumRandom; n++) begin
			calm = ((n / 60) % 3) == 1;
			if (n == 200) begin
				s_tvalid <= 1'b0;
				wait (draws_due.size() == 0);
				@(posedge clk);
			end
			offer_count(random_count(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		wait (draws_due.size() == 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("lottery_random_mod test passed");
		else
			$display("lottery_random_mod test failed");
		$finish;
	end

	// Master side: stall at random, then take one transaction and check it.
	initial begin
		int                            stall;
		logic [lrm_pkg::DrawWidth-1:0] want;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (draws_due.size() == 0) begin
				$error("draw: expected none, actual %0d", m_tdata[lrm_pkg::DrawWidth-1:0]);
				errors++;
			end else begin
				want = draws_due.pop_front();
				if (m_tdata[lrm_pkg::DrawWidth-1:0] !== want) begin
					$error("draw: expected %0d, actual %0d", want,
					       m_tdata[lrm_pkg::DrawWidth-1:0]);
					errors++;
				end
			end
		end
	end

endmodule
